[rtl/core/mtfr_pkg.sv]
// mtfr_pkg: constants, types and word functions for the mt19937 forward/reverse stream unit
// no dependencies; imported by the unit and by mtfr_checker

package mtfr_pkg;

  // generator geometry
  localparam int STATE_WORDS = 624;
  localparam int TAP_OFFSET  = 397;
  localparam int FWD_START   = TAP_OFFSET - 1;
  localparam int REV_START   = STATE_WORDS - TAP_OFFSET - 1;
  localparam int REV_VALID   = STATE_WORDS - TAP_OFFSET;

  localparam int WORD_W = 32;
  localparam int HIST_W = $clog2(STATE_WORDS);
  localparam int RING_W = $clog2(TAP_OFFSET);
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  localparam logic [WORD_W-1:0] HI_BIT      = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LO_BITS     = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TWIST_XOR   = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] TEMPER_B    = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C    = 32'hEFC6_0000;
  localparam logic [WORD_W-1:0] RUN_LEN_RST = 32'(STATE_WORDS);

  // input item kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_GEN  = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HIST_W-1:0] hist_t;
  typedef logic [RING_W-1:0] ring_t;

  // run phase, one-hot
  typedef enum logic [2:0] {
    PH_FWD  = 3'b001,
    PH_REV  = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  // one result item
  typedef struct packed {
    logic  last;
    word_t step_index;
    logic  reverse_phase;
    word_t random_word;
  } result_t;

  // output tempering
  function automatic word_t temper(input word_t v);
    word_t y;
    y = v;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // advance a pointer around the tap-length rings
  function automatic ring_t ring_next(input ring_t v);
    return (v < RING_W'(TAP_OFFSET - 1)) ? ring_t'(v + 1'b1) : '0;
  endfunction

  // step the recent-word pointer backward with wrap
  function automatic hist_t hist_dec(input hist_t v);
    return (v == '0) ? HIST_W'(STATE_WORDS - 1) : hist_t'(v - 1'b1);
  endfunction

  // step the recent-word pointer forward with wrap
  function automatic hist_t hist_inc(input hist_t v);
    return (v < HIST_W'(STATE_WORDS - 1)) ? hist_t'(v + 1'b1) : '0;
  endfunction

endpackage

[rtl/core/mt19937_forward_reverse_stream_unit.sv]
// mt19937_forward_reverse_stream_unit: raw-state mt19937 word stream, forward then backward
// depends on mtfr_pkg; four on-chip memories hold loaded, recent, delayed and pending words

// A load transfer (tuser 0) writes one of the 624 state words and restarts the run; a
// generate transfer (tuser 1) returns one tempered word: run_length words forward, then
// run_length words backward starting by repeating the last forward word, then nothing until
// the next load. Loads and ticks alike are taken, so the unit sustains one item per clock
// unless the output stalls. It rests on registered reads of the four word memories, each
// read ahead at the pointer it will need next, with a write bypass for the entry being
// written in that cycle. Results go through an output register and a skid register;
// in_tready drops only when both hold untaken results. The memories need no clearing
// pass after reset; reading a state word that was never loaded gives an undefined result
// word. run_length may be written only while the unit is idle.

module mt19937_forward_reverse_stream_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [mtfr_pkg::WORD_W-1:0]     cfg_wdata,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mtfr_pkg::IN_DATA_W-1:0]  in_tdata,   // word_index[9:0], word_value[41:10]
  input  logic [0:0]                      in_tuser,   // op
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mtfr_pkg::OUT_DATA_W-1:0] out_tdata,  // random_word[31:0], step_index[63:32]
  output logic [0:0]                      out_tuser,  // reverse_phase
  output logic                            out_tlast   // last
);
  import mtfr_pkg::*;

  // memories
  word_t init_mem    [STATE_WORDS];
  word_t recent_mem  [STATE_WORDS];
  word_t delay_mem   [TAP_OFFSET];
  word_t pend_mem    [TAP_OFFSET];

  // control state
  word_t  run_len_r;
  phase_t phase_r, phase_nxt;
  word_t  tick_r, tick_nxt;
  hist_t  hist_r, hist_nxt;
  ring_t  tap_rd_r, tap_rd_nxt, tap_wr_r, tap_wr_nxt;
  ring_t  pend_rd_r, pend_rd_nxt, pend_wr_r, pend_wr_nxt;
  logic   valid_r, valid_nxt;
  word_t  dly_a_r, dly_a_nxt, dly_b_r, dly_b_nxt, prior_r, prior_nxt;

  // memory read data and bypass
  word_t init_rd_r, recent_rd_r, delay_rd_r, pend_rd_data_r;
  word_t init_byp_r, recent_byp_r, delay_byp_r, pend_byp_r;
  logic  init_hit_r, recent_hit_r, delay_hit_r, pend_hit_r;
  word_t init_q, recent_q, delay_q, pend_q;

  // memory ports
  logic  init_we, recent_we, delay_we, pend_we;
  hist_t init_wa, init_ra, recent_wa, recent_ra;
  ring_t delay_wa, delay_ra, pend_wa, pend_ra;
  word_t pend_wd;

  // tick decode
  logic    in_fire, tick_fire, load_fire, load_ok;
  logic    begin_rev, rev_over, no_result, emit;
  logic    eff_rev, low_idx, fwd_mix, rev_mix;
  word_t   eff_i, x, new_b, mix, tw, z, y, q;
  hist_t   eff_h;
  ring_t   eff_tap_rd, eff_tap_wr, eff_pend_rd, eff_pend_wr;
  logic    eff_valid;
  word_t   eff_prior;
  hist_t   in_word_index;
  logic [9:0] in_index_raw;
  word_t   in_word_value;
  result_t res;

  // output register and skid
  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  logic    out_take;

  // input field unpacking
  assign in_index_raw  = in_tdata[9:0];
  assign in_word_index = in_index_raw[HIST_W-1:0];
  assign in_word_value = in_tdata[41:10];

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign tick_fire = in_fire && (in_tuser[0] == OP_GEN);
  assign load_fire = in_fire && (in_tuser[0] == OP_LOAD);
  assign load_ok   = load_fire && (in_index_raw < 10'(STATE_WORDS));

  // effective bypassed read data
  assign init_q   = init_hit_r   ? init_byp_r   : init_rd_r;
  assign recent_q = recent_hit_r ? recent_byp_r : recent_rd_r;
  assign delay_q  = delay_hit_r  ? delay_byp_r  : delay_rd_r;
  assign pend_q   = pend_hit_r   ? pend_byp_r   : pend_rd_data_r;

  // tick datapath and next state
  always_comb begin
    begin_rev = (phase_r == PH_FWD) && (tick_r >= run_len_r);
    rev_over  = (phase_r == PH_REV) && (tick_r >= run_len_r);
    no_result = (phase_r == PH_DONE) || rev_over || (begin_rev && (run_len_r == '0));
    emit      = tick_fire && !no_result;

    eff_rev     = begin_rev || (phase_r == PH_REV);
    eff_i       = begin_rev ? '0 : tick_r;
    eff_h       = begin_rev ? hist_dec(hist_r) : hist_r;
    eff_tap_rd  = begin_rev ? '0 : tap_rd_r;
    eff_tap_wr  = begin_rev ? '0 : tap_wr_r;
    eff_pend_rd = begin_rev ? '0 : pend_rd_r;
    eff_pend_wr = begin_rev ? '0 : pend_wr_r;
    eff_valid   = begin_rev ? 1'b0 : valid_r;
    eff_prior   = begin_rev ? '0 : prior_r;

    // word for this tick
    low_idx = eff_i < WORD_W'(STATE_WORDS);
    x = low_idx ? (eff_rev ? recent_q : init_q) : pend_q;

    // forward recurrence and reverse inversion
    fwd_mix = !eff_rev && (eff_i >= WORD_W'(FWD_START));
    rev_mix = eff_rev && (eff_i >= WORD_W'(REV_START));
    new_b   = delay_q;
    mix     = (dly_b_r & HI_BIT) | (new_b & LO_BITS);
    tw      = (new_b[0] ? TWIST_XOR : '0) ^ (mix >> 1);
    z       = dly_b_r ^ x;
    y       = z ^ (z[WORD_W-1] ? TWIST_XOR : '0);
    q       = {y[WORD_W-2:0], z[WORD_W-1]};
    pend_wd = fwd_mix ? (x ^ tw) : {eff_prior[WORD_W-1], q[WORD_W-2:0]};

    res.random_word   = temper(x);
    res.reverse_phase = eff_rev;
    res.step_index    = eff_i;
    res.last          = eff_rev && (eff_i == (run_len_r - 1'b1));

    // defaults hold
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    hist_nxt    = hist_r;
    tap_rd_nxt  = tap_rd_r;
    tap_wr_nxt  = tap_wr_r;
    pend_rd_nxt = pend_rd_r;
    pend_wr_nxt = pend_wr_r;
    valid_nxt   = valid_r;
    dly_a_nxt   = dly_a_r;
    dly_b_nxt   = dly_b_r;
    prior_nxt   = prior_r;

    recent_we = 1'b0;
    delay_we  = 1'b0;
    pend_we   = 1'b0;

    if (load_ok) begin
      // restart the run
      phase_nxt   = PH_FWD;
      tick_nxt    = '0;
      hist_nxt    = '0;
      tap_rd_nxt  = '0;
      tap_wr_nxt  = '0;
      pend_rd_nxt = '0;
      pend_wr_nxt = '0;
      valid_nxt   = 1'b0;
      dly_a_nxt   = '0;
      dly_b_nxt   = '0;
      prior_nxt   = '0;
    end else if (tick_fire && no_result) begin
      phase_nxt = PH_DONE;
    end else if (emit) begin
      phase_nxt   = eff_rev ? PH_REV : PH_FWD;
      tap_rd_nxt  = eff_tap_rd;
      pend_rd_nxt = low_idx ? eff_pend_rd : ring_next(eff_pend_rd);
      pend_wr_nxt = eff_pend_wr;
      valid_nxt   = eff_valid;
      prior_nxt   = eff_prior;
      if (fwd_mix || rev_mix) begin
        dly_a_nxt  = dly_b_r;
        dly_b_nxt  = new_b;
        tap_rd_nxt = ring_next(eff_tap_rd);
        pend_we    = eff_valid;
        if (eff_valid) begin
          pend_wr_nxt = ring_next(eff_pend_wr);
        end
        if (fwd_mix) begin
          valid_nxt = 1'b1;
        end else begin
          prior_nxt = q;
          if (eff_i >= WORD_W'(REV_VALID)) begin
            valid_nxt = 1'b1;
          end
        end
      end
      delay_we   = 1'b1;
      tap_wr_nxt = ring_next(eff_tap_wr);
      recent_we  = 1'b1;
      hist_nxt   = eff_rev ? hist_dec(eff_h) : hist_inc(eff_h);
      tick_nxt   = eff_i + 1'b1;
    end
  end

  // memory addresses, reads are registered ahead of use
  assign init_we   = load_ok;
  assign init_wa   = in_word_index;
  assign init_ra   = tick_nxt[HIST_W-1:0];
  assign recent_wa = eff_h;
  assign recent_ra = (phase_nxt == PH_FWD) ? hist_dec(hist_nxt) : hist_nxt;
  assign delay_wa  = eff_tap_wr;
  assign delay_ra  = tap_rd_nxt;
  assign pend_wa   = eff_pend_wr;
  assign pend_ra   = pend_rd_nxt;

  // loaded state words
  always_ff @(posedge clk) begin
    if (init_we) begin
      init_mem[init_wa] <= in_word_value;
    end
    init_rd_r  <= init_mem[init_ra];
    init_hit_r <= init_we && (init_wa == init_ra);
    init_byp_r <= in_word_value;
  end

  // words seen in the run
  always_ff @(posedge clk) begin
    if (recent_we) begin
      recent_mem[recent_wa] <= x;
    end
    recent_rd_r  <= recent_mem[recent_ra];
    recent_hit_r <= recent_we && (recent_wa == recent_ra);
    recent_byp_r <= x;
  end

  // recurrence delay line
  always_ff @(posedge clk) begin
    if (delay_we) begin
      delay_mem[delay_wa] <= x;
    end
    delay_rd_r  <= delay_mem[delay_ra];
    delay_hit_r <= delay_we && (delay_wa == delay_ra);
    delay_byp_r <= x;
  end

  // computed words waiting to be emitted
  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_wa] <= pend_wd;
    end
    pend_rd_data_r <= pend_mem[pend_ra];
    pend_hit_r     <= pend_we && (pend_wa == pend_ra);
    pend_byp_r     <= pend_wd;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r <= RUN_LEN_RST;
      phase_r   <= PH_FWD;
      tick_r    <= '0;
      hist_r    <= '0;
      tap_rd_r  <= '0;
      tap_wr_r  <= '0;
      pend_rd_r <= '0;
      pend_wr_r <= '0;
      valid_r   <= 1'b0;
      dly_a_r   <= '0;
      dly_b_r   <= '0;
      prior_r   <= '0;
    end else begin
      if (cfg_we) begin
        run_len_r <= cfg_wdata;
      end
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      hist_r    <= hist_nxt;
      tap_rd_r  <= tap_rd_nxt;
      tap_wr_r  <= tap_wr_nxt;
      pend_rd_r <= pend_rd_nxt;
      pend_wr_r <= pend_wr_nxt;
      valid_r   <= valid_nxt;
      dly_a_r   <= dly_a_nxt;
      dly_b_r   <= dly_b_nxt;
      prior_r   <= prior_nxt;
    end
  end

  // output register with skid stage
  assign out_take = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (out_take || !out_valid_r) begin
      out_valid_r <= emit;
    end else if (emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (out_take || !out_valid_r) begin
      out_data_r <= res;
    end else if (emit) begin
      skid_data_r <= res;
    end
  end

  // result port packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.step_index, out_data_r.random_word};
  assign out_tuser  = out_data_r.reverse_phase;
  assign out_tlast  = out_data_r.last;

endmodule

[rtl/core/mtfr_checker.sv]
// mtfr_checker: port-level assertions for the mt19937 forward/reverse stream unit
// depends on mtfr_pkg; bound to mt19937_forward_reverse_stream_unit below

module mtfr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mtfr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                      out_tuser,
  input logic                            out_tlast
);
  import mtfr_pkg::*;

  // reset leaves no result pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("result or back-pressure after reset");

  // the final word only exists in the reverse run
  a_last_reverse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[0])
    else $error("last marked outside the reverse run");

  // input back-pressure only with a result held at the output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with an empty output");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind mt19937_forward_reverse_stream_unit mtfr_checker u_mtfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
